// ===== sv/bpc_pkg.sv =====
// Shared payload types and register indexes for the ball pair collision block.
`default_nettype none
package bpc_pkg;

    localparam int POS_W  = 18;
    localparam int VEL_W  = 24;
    localparam int MASS_W = 16;
    localparam int CFG_W  = 16;

    localparam logic [1:0] CFG_CONTACT     = 2'd0;
    localparam logic [1:0] CFG_RESTITUTION = 2'd1;
    localparam logic [1:0] CFG_OVERLAP     = 2'd2;

    localparam logic [CFG_W-1:0] CONTACT_RST     = 16'd1311;
    localparam logic [CFG_W-1:0] RESTITUTION_RST = 16'd6554;

    typedef struct packed {
        logic [POS_W-1:0]         pos_x_a;
        logic [POS_W-1:0]         pos_y_a;
        logic signed [VEL_W-1:0]  vel_x_a;
        logic signed [VEL_W-1:0]  vel_y_a;
        logic [MASS_W-1:0]        mass_a;
        logic [POS_W-1:0]         pos_x_b;
        logic [POS_W-1:0]         pos_y_b;
        logic signed [VEL_W-1:0]  vel_x_b;
        logic signed [VEL_W-1:0]  vel_y_b;
        logic [MASS_W-1:0]        mass_b;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]         new_pos_x_a;
        logic [POS_W-1:0]         new_pos_y_a;
        logic signed [VEL_W-1:0]  new_vel_x_a;
        logic signed [VEL_W-1:0]  new_vel_y_a;
        logic [POS_W-1:0]         new_pos_x_b;
        logic [POS_W-1:0]         new_pos_y_b;
        logic signed [VEL_W-1:0]  new_vel_x_b;
        logic signed [VEL_W-1:0]  new_vel_y_b;
        logic                     collided;
    } t_out_item;

endpackage
`default_nettype wire

// ===== sv/bpc_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a sideband.
`default_nettype none
module bpc_sqrt #(
    parameter int RW = 16,
    parameter int SW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire logic [2*RW-1:0] i_rad,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_vld,
    output logic [RW-1:0]        o_root,
    output logic [SW-1:0]        o_side
);

    logic [RW:0]     r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_rad  [RW];
    logic [SW-1:0]   r_side [RW];
    logic            r_vld  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        logic [RW:0]     rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] rad_in;
        logic [SW-1:0]   side_in;
        logic            vld_in;
        logic [RW+2:0]   trial_rem;
        logic [RW+2:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign trial_rem = {rem_in, rad_in[2*RW-1 -: 2]};
        assign trial     = {1'b0, root_in, 2'b01};
        assign ge        = (trial_rem >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (RW+1)'(trial_rem - trial) : (RW+1)'(trial_rem);
                r_root[k] <= {root_in[RW-2:0], ge};
                r_rad[k]  <= {rad_in[2*RW-3:0], 2'b00};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule
`default_nettype wire

// ===== sv/bpc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage, with a sideband.
`default_nettype none
module bpc_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_div,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic [QW-1:0]      o_quot,
    output logic [SW-1:0]      o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_num  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [DW-1:0] r_div  [QW];
    logic [SW-1:0] r_side [QW];
    logic          r_vld  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic [DW-1:0] rem_in;
        logic [QW-1:0] num_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] div_in;
        logic [SW-1:0] side_in;
        logic          vld_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            // The caller guarantees the quotient fits, so the top bits start below the divisor.
            assign rem_in  = DW'(i_num[NW-1:QW]);
            assign num_in  = i_num[QW-1:0];
            assign q_in    = '0;
            assign div_in  = i_div;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign num_in  = r_num[k-1];
            assign q_in    = r_q[k-1];
            assign div_in  = r_div[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign trial = {rem_in, num_in[QW-1]};
        assign ge    = (trial >= {1'b0, div_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? DW'(trial - {1'b0, div_in}) : DW'(trial);
                r_num[k]  <= {num_in[QW-2:0], 1'b0};
                r_q[k]    <= {q_in[QW-2:0], ge};
                r_div[k]  <= div_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quot = r_q[QW-1];
    assign o_side = r_side[QW-1];

endmodule
`default_nettype wire

// ===== sv/ball_pair_collision_response_top.sv =====
// Top level of the ball pair collision response pipeline.
//
// Usage: one ball pair enters on the input channel (i_in_valid / o_in_ready,
// payload i_in_data) and exactly one updated pair leaves on the output channel
// (o_out_valid / i_out_ready, payload o_out_data) in the same order.
// Throughput is one item per cycle while the receiver does not stall. On its way
// to o_out_valid an item passes three setup stages, 16 square-root stages, 17
// stages for the unit normal division, five stages for the normal velocity and
// impulse numerators, 43 stages for the mass-weighted impulse division and three
// stages to apply the result into the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken; when the receiver stalls, every stage holds its item and
// o_in_ready drops, so nothing is lost or repeated.
// Registers (contact distance, restitution, overlap correction) are written through
// i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight; the block leaves this to the user.
// Synchronous reset empties the pipeline and loads the register defaults.
`default_nettype none
module ball_pair_collision_response_top
    import bpc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    typedef struct packed {
        t_in_item           pkt;
        logic signed [18:0] dx;
        logic signed [18:0] dy;
        logic               contact;
    } t_sq_side;

    typedef struct packed {
        t_in_item    pkt;
        logic        sx;
        logic        contact;
        logic [15:0] d;
    } t_nx_side;

    typedef struct packed {
        t_in_item           pkt;
        logic               hit;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic [15:0]        ov;
    } t_k_side;

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [30:0] v);
        if (v > 31'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -31'sd8388608) begin
            return 24'sh800000;
        end
        return VEL_W'(v);
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [19:0] v);
        if (v > 20'sd262143) begin
            return 18'h3FFFF;
        end else if (v < 20'sd0) begin
            return '0;
        end
        return POS_W'(v);
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] r_contact;
    logic [CFG_W-1:0] r_rest;
    logic             r_ovc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contact <= CONTACT_RST;
            r_rest    <= RESTITUTION_RST;
            r_ovc     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CONTACT:     r_contact <= i_cfg_data;
                CFG_RESTITUTION: r_rest    <= i_cfg_data;
                CFG_OVERLAP:     r_ovc     <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end

    logic en;
    logic r12_vld;
    assign en         = ~r12_vld | i_out_ready;
    assign o_in_ready = en;

    // Stage 1: coordinate differences.
    logic               r1_vld;
    t_in_item           r1_pkt;
    logic signed [18:0] r1_dx, r1_dy;
    logic               r1_mnz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pkt <= i_in_data;
            r1_dx  <= $signed({1'b0, i_in_data.pos_x_b}) - $signed({1'b0, i_in_data.pos_x_a});
            r1_dy  <= $signed({1'b0, i_in_data.pos_y_b}) - $signed({1'b0, i_in_data.pos_y_a});
            r1_mnz <= (i_in_data.mass_a != '0) || (i_in_data.mass_b != '0);
        end
    end

    // Stage 2: squared distance.
    logic               r2_vld;
    t_in_item           r2_pkt;
    logic signed [18:0] r2_dx, r2_dy;
    logic               r2_mnz;
    logic [36:0]        r2_d2;
    logic signed [37:0] sq_x, sq_y;

    assign sq_x = r1_dx * r1_dx;
    assign sq_y = r1_dy * r1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pkt <= r1_pkt;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_mnz <= r1_mnz;
            r2_d2  <= 37'(sq_x) + 37'(sq_y);
        end
    end

    // Stage 3: contact test on the squared distance; floor(sqrt(d2)) < c iff d2 < c*c.
    logic        r3_vld;
    t_sq_side    r3_side;
    logic [31:0] r3_d2;
    logic [31:0] c_sq;

    assign c_sq = r_contact * r_contact;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side.pkt     <= r2_pkt;
            r3_side.dx      <= r2_dx;
            r3_side.dy      <= r2_dy;
            r3_side.contact <= (r2_d2 != '0) && (r2_d2 < {5'b0, c_sq}) && r2_mnz;
            r3_d2           <= r2_d2[31:0];
        end
    end

    // Distance.
    logic        sq_vld;
    logic [15:0] sq_root;
    t_sq_side    sq_o;

    bpc_sqrt #(.RW(16), .SW($bits(t_sq_side))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_rad   (r3_d2),
        .i_side  (r3_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_o)
    );

    // Unit normal: |dx| <= d inside contact, so the quotient fits in 17 bits.
    logic [18:0] ax, ay;
    t_nx_side    nxs_in;

    assign ax = sq_o.dx[18] ? 19'(-sq_o.dx) : 19'(sq_o.dx);
    assign ay = sq_o.dy[18] ? 19'(-sq_o.dy) : 19'(sq_o.dy);

    assign nxs_in.pkt     = sq_o.pkt;
    assign nxs_in.sx      = sq_o.dx[18];
    assign nxs_in.contact = sq_o.contact;
    assign nxs_in.d       = sq_root;

    logic        nx_vld, ny_vld;
    logic [16:0] qx, qy;
    t_nx_side    nxs_o;
    logic        sy_o;

    bpc_div #(.NW(32), .DW(16), .QW(17), .SW($bits(t_nx_side))) u_div_nx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_num   ({ax[15:0], 16'b0}),
        .i_div   (sq_root),
        .i_side  (nxs_in),
        .o_vld   (nx_vld),
        .o_quot  (qx),
        .o_side  (nxs_o)
    );

    bpc_div #(.NW(32), .DW(16), .QW(17), .SW(1)) u_div_ny (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_num   ({ay[15:0], 16'b0}),
        .i_div   (sq_root),
        .i_side  (sq_o.dy[18]),
        .o_vld   (ny_vld),
        .o_quot  (qy),
        .o_side  (sy_o)
    );

    // Stage 5: signed normal, overlap and relative velocity products.
    logic signed [17:0] nx_c, ny_c;
    logic signed [24:0] dvx, dvy;

    assign nx_c = nxs_o.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign ny_c = sy_o     ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    assign dvx  = 25'(nxs_o.pkt.vel_x_b) - 25'(nxs_o.pkt.vel_x_a);
    assign dvy  = 25'(nxs_o.pkt.vel_y_b) - 25'(nxs_o.pkt.vel_y_a);

    logic               r5_vld;
    t_in_item           r5_pkt;
    logic               r5_contact;
    logic signed [17:0] r5_nx, r5_ny;
    logic [15:0]        r5_ov;
    logic signed [42:0] r5_px, r5_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= nx_vld & ny_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_pkt     <= nxs_o.pkt;
            r5_contact <= nxs_o.contact;
            r5_nx      <= nx_c;
            r5_ny      <= ny_c;
            r5_ov      <= r_contact - nxs_o.d;
            r5_px      <= dvx * nx_c;
            r5_py      <= dvy * ny_c;
        end
    end

    // Stage 6: normal velocity; arithmetic shift gives the floor.
    logic signed [43:0] dot_sum;
    assign dot_sum = 44'(r5_px) + 44'(r5_py);

    logic               r6_vld;
    t_in_item           r6_pkt;
    logic               r6_hit;
    logic signed [17:0] r6_nx, r6_ny;
    logic [15:0]        r6_ov;
    logic signed [27:0] r6_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_pkt <= r5_pkt;
            r6_hit <= r5_contact & dot_sum[43];
            r6_nx  <= r5_nx;
            r6_ny  <= r5_ny;
            r6_ov  <= r5_ov;
            r6_dot <= dot_sum[43:16];
        end
    end

    // Stage 7: base impulse 2*dot*restitution.
    logic signed [44:0] base_p;
    assign base_p = r6_dot * $signed({1'b0, r_rest});

    logic               r7_vld;
    t_k_side            r7_side;
    logic signed [44:0] r7_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_side.pkt <= r6_pkt;
            r7_side.hit <= r6_hit;
            r7_side.nx  <= r6_nx;
            r7_side.ny  <= r6_ny;
            r7_side.ov  <= r6_ov;
            r7_base     <= {base_p[43:0], 1'b0};
        end
    end

    // Stage 8: magnitude times the other mass, split into two partial products.
    logic [44:0] babs;
    assign babs = r7_base[44] ? 45'(-r7_base) : 45'(r7_base);

    logic        r8_vld;
    t_k_side     r8_side;
    logic        r8_bneg;
    logic [36:0] r8_pa_hi, r8_pb_hi;
    logic [37:0] r8_pa_lo, r8_pb_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_side  <= r7_side;
            r8_bneg  <= r7_base[44];
            r8_pa_hi <= babs[42:22] * r7_side.pkt.mass_b;
            r8_pa_lo <= babs[21:0] * r7_side.pkt.mass_b;
            r8_pb_hi <= babs[42:22] * r7_side.pkt.mass_a;
            r8_pb_lo <= babs[21:0] * r7_side.pkt.mass_a;
        end
    end

    // Stage 9: full numerators.
    logic        r9_vld;
    t_k_side     r9_side;
    logic        r9_bneg;
    logic [58:0] r9_numa, r9_numb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (en) begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_side <= r8_side;
            r9_bneg <= r8_bneg;
            r9_numa <= (59'(r8_pa_hi) << 22) + 59'(r8_pa_lo);
            r9_numb <= (59'(r8_pb_hi) << 22) + 59'(r8_pb_lo);
        end
    end

    // Mass-weighted impulse; the quotient is bounded by |base| < 2^43.
    logic [16:0] msum;
    assign msum = {1'b0, r9_side.pkt.mass_a} + {1'b0, r9_side.pkt.mass_b};

    logic        ka_vld, kb_vld;
    logic [42:0] qa, qb;
    t_k_side     ks_o;
    logic        bneg_o;

    bpc_div #(.NW(59), .DW(17), .QW(43), .SW($bits(t_k_side))) u_div_ka (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r9_vld),
        .i_num   (r9_numa),
        .i_div   (msum),
        .i_side  (r9_side),
        .o_vld   (ka_vld),
        .o_quot  (qa),
        .o_side  (ks_o)
    );

    bpc_div #(.NW(59), .DW(17), .QW(43), .SW(1)) u_div_kb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r9_vld),
        .i_num   (r9_numb),
        .i_div   (msum),
        .i_side  (r9_bneg),
        .o_vld   (kb_vld),
        .o_quot  (qb),
        .o_side  (bneg_o)
    );

    // Stage 10: signed impulse scaled down with floor.
    logic signed [43:0] sqa, sqb;
    assign sqa = bneg_o ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
    assign sqb = bneg_o ? -$signed({1'b0, qb}) : $signed({1'b0, qb});

    logic               r10_vld;
    t_k_side            r10_side;
    logic signed [27:0] r10_ka, r10_kb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (en) begin
            r10_vld <= ka_vld & kb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_side <= ks_o;
            r10_ka   <= sqa[43:16];
            r10_kb   <= sqb[43:16];
        end
    end

    // Stage 11: velocity and position deltas along the normal.
    logic               r11_vld;
    t_in_item           r11_pkt;
    logic               r11_hit;
    logic signed [45:0] r11_pax, r11_pay, r11_pbx, r11_pby;
    logic signed [34:0] r11_psx, r11_psy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else if (en) begin
            r11_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_pkt <= r10_side.pkt;
            r11_hit <= r10_side.hit;
            r11_pax <= r10_ka * r10_side.nx;
            r11_pay <= r10_ka * r10_side.ny;
            r11_pbx <= r10_kb * r10_side.nx;
            r11_pby <= r10_kb * r10_side.ny;
            r11_psx <= $signed({1'b0, r10_side.ov}) * r10_side.nx;
            r11_psy <= $signed({1'b0, r10_side.ov}) * r10_side.ny;
        end
    end

    // Stage 12: apply, saturate and register the result.
    logic signed [30:0] vxa_s, vya_s, vxb_s, vyb_s;
    logic signed [19:0] xa_s, ya_s, xb_s, yb_s;
    logic signed [17:0] shx, shy;
    t_out_item          res;

    assign shx   = r11_psx[34:17];
    assign shy   = r11_psy[34:17];
    assign vxa_s = 31'(r11_pkt.vel_x_a) + 31'($signed(r11_pax[45:16]));
    assign vya_s = 31'(r11_pkt.vel_y_a) + 31'($signed(r11_pay[45:16]));
    assign vxb_s = 31'(r11_pkt.vel_x_b) - 31'($signed(r11_pbx[45:16]));
    assign vyb_s = 31'(r11_pkt.vel_y_b) - 31'($signed(r11_pby[45:16]));
    assign xa_s  = $signed({2'b0, r11_pkt.pos_x_a}) - 20'(shx);
    assign ya_s  = $signed({2'b0, r11_pkt.pos_y_a}) - 20'(shy);
    assign xb_s  = $signed({2'b0, r11_pkt.pos_x_b}) + 20'(shx);
    assign yb_s  = $signed({2'b0, r11_pkt.pos_y_b}) + 20'(shy);

    always_comb begin
        res.new_pos_x_a = r11_pkt.pos_x_a;
        res.new_pos_y_a = r11_pkt.pos_y_a;
        res.new_vel_x_a = r11_pkt.vel_x_a;
        res.new_vel_y_a = r11_pkt.vel_y_a;
        res.new_pos_x_b = r11_pkt.pos_x_b;
        res.new_pos_y_b = r11_pkt.pos_y_b;
        res.new_vel_x_b = r11_pkt.vel_x_b;
        res.new_vel_y_b = r11_pkt.vel_y_b;
        res.collided    = r11_hit;
        if (r11_hit) begin
            res.new_vel_x_a = sat_vel(vxa_s);
            res.new_vel_y_a = sat_vel(vya_s);
            res.new_vel_x_b = sat_vel(vxb_s);
            res.new_vel_y_b = sat_vel(vyb_s);
            if (r_ovc) begin
                res.new_pos_x_a = sat_pos(xa_s);
                res.new_pos_y_a = sat_pos(ya_s);
                res.new_pos_x_b = sat_pos(xb_s);
                res.new_pos_y_b = sat_pos(yb_s);
            end
        end
    end

    t_out_item r12_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_vld <= 1'b0;
        end else if (en) begin
            r12_vld <= r11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_out <= res;
        end
    end

    assign o_out_valid = r12_vld;
    assign o_out_data  = r12_out;

endmodule
`default_nettype wire
